@@ rtl/core/psr_pkg.sv @@
// ----------------------------------------------------------------------------
// PID speed regulator package
// Shared constants, register map, request codes and pipeline payload types.
// ----------------------------------------------------------------------------
package psr_pkg;

	localparam int unsigned FracBits = 24;
	localparam int unsigned AddrW    = 5;

	localparam logic [15:0]        SetpointRst    = 16'd1000;
	localparam logic signed [31:0] GainPropRst    = -32'sd100663;
	localparam logic signed [31:0] GainIntegRst   = -32'sd201;
	localparam logic signed [31:0] GainDerivRst   = -32'sd335544;
	localparam logic [15:0]        DutyFloorRst   = 16'd0;
	localparam logic [15:0]        DutyCeilingRst = 16'd65535;
	localparam logic [15:0]        DutyDefaultRst = 16'd32768;

	typedef enum logic [2:0] {
		REG_SETPOINT     = 3'd0,
		REG_GAIN_PROP    = 3'd1,
		REG_GAIN_INTEG   = 3'd2,
		REG_GAIN_DERIV   = 3'd3,
		REG_DUTY_FLOOR   = 3'd4,
		REG_DUTY_CEILING = 3'd5,
		REG_DUTY_DEFAULT = 3'd6
	} reg_idx_t;

	typedef enum logic {
		REQ_TICK    = 1'b0,
		REQ_RESTART = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [15:0]        setpoint;
		logic signed [31:0] gain_prop;
		logic signed [31:0] gain_integ;
		logic signed [31:0] gain_deriv;
		logic [15:0]        duty_floor;
		logic [15:0]        duty_ceiling;
		logic [15:0]        duty_default;
	} cfg_t;

	typedef struct packed {
		logic               restart;
		logic signed [16:0] err;
		logic signed [31:0] esum;
		logic signed [17:0] deriv;
	} err_pl_t;

	typedef struct packed {
		logic               restart;
		logic signed [39:0] corr;
	} corr_pl_t;

endpackage

@@ rtl/core/psr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// PID speed regulator configuration registers
// APB-style register file holding setpoint, gains and duty limits.
// ----------------------------------------------------------------------------
module psr_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [psr_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output psr_pkg::cfg_t              cfg
);
	import psr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint     <= SetpointRst;
			cfg_q.gain_prop    <= GainPropRst;
			cfg_q.gain_integ   <= GainIntegRst;
			cfg_q.gain_deriv   <= GainDerivRst;
			cfg_q.duty_floor   <= DutyFloorRst;
			cfg_q.duty_ceiling <= DutyCeilingRst;
			cfg_q.duty_default <= DutyDefaultRst;
		end else if (wr_en) begin
			unique case (idx)
				REG_SETPOINT:     cfg_q.setpoint     <= pwdata[15:0];
				REG_GAIN_PROP:    cfg_q.gain_prop    <= $signed(pwdata);
				REG_GAIN_INTEG:   cfg_q.gain_integ   <= $signed(pwdata);
				REG_GAIN_DERIV:   cfg_q.gain_deriv   <= $signed(pwdata);
				REG_DUTY_FLOOR:   cfg_q.duty_floor   <= pwdata[15:0];
				REG_DUTY_CEILING: cfg_q.duty_ceiling <= pwdata[15:0];
				REG_DUTY_DEFAULT: cfg_q.duty_default <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SETPOINT:     prdata = {16'd0, cfg_q.setpoint};
			REG_GAIN_PROP:    prdata = $unsigned(cfg_q.gain_prop);
			REG_GAIN_INTEG:   prdata = $unsigned(cfg_q.gain_integ);
			REG_GAIN_DERIV:   prdata = $unsigned(cfg_q.gain_deriv);
			REG_DUTY_FLOOR:   prdata = {16'd0, cfg_q.duty_floor};
			REG_DUTY_CEILING: prdata = {16'd0, cfg_q.duty_ceiling};
			REG_DUTY_DEFAULT: prdata = {16'd0, cfg_q.duty_default};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/core/psr_err_track.sv @@
// ----------------------------------------------------------------------------
// PID speed regulator error tracking stage
// Forms the speed error, the saturating integral and the error difference.
// ----------------------------------------------------------------------------
module psr_err_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         setpoint,
	input  logic                up_valid,
	output logic                up_ready,
	input  logic                up_restart,
	input  logic [15:0]         up_speed,
	output logic                dn_valid,
	input  logic                dn_ready,
	output psr_pkg::err_pl_t    dn
);
	import psr_pkg::*;

	logic               v_s2;
	err_pl_t            pl_s2;
	logic signed [31:0] err_sum_q;
	logic signed [16:0] err_prev_q;

	logic               take;
	logic signed [16:0] err;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_sat;
	logic signed [17:0] deriv;

	assign up_ready = !v_s2 || dn_ready;
	assign take     = up_valid && up_ready;
	assign dn_valid = v_s2;
	assign dn       = pl_s2;

	always_comb begin
		err      = $signed({1'b0, up_speed}) - $signed({1'b0, setpoint});
		sum_wide = {{16{err[16]}}, err} + {err_sum_q[31], err_sum_q};
		if (sum_wide[32] != sum_wide[31]) begin
			sum_sat = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			sum_sat = sum_wide[31:0];
		end
		deriv = {err[16], err} - {err_prev_q[16], err_prev_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			err_sum_q  <= '0;
			err_prev_q <= '0;
		end else begin
			if (take) begin
				v_s2 <= 1'b1;
				if (up_restart) begin
					err_sum_q  <= '0;
					err_prev_q <= '0;
				end else begin
					err_sum_q  <= sum_sat;
					err_prev_q <= err;
				end
			end else if (dn_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pl_s2.restart <= up_restart;
			pl_s2.err     <= err;
			pl_s2.esum    <= sum_sat;
			pl_s2.deriv   <= deriv;
		end
	end

endmodule

@@ rtl/core/psr_gain_mult.sv @@
// ----------------------------------------------------------------------------
// PID speed regulator gain stages
// Multiplies the three error terms by their gains, then sums and rescales.
// ----------------------------------------------------------------------------
module psr_gain_mult (
	input  logic                clk,
	input  logic                arst_n,
	input  psr_pkg::cfg_t       cfg,
	input  logic                up_valid,
	output logic                up_ready,
	input  psr_pkg::err_pl_t    up,
	output logic                dn_valid,
	input  logic                dn_ready,
	output psr_pkg::corr_pl_t   dn
);
	import psr_pkg::*;

	logic               v_s3;
	logic               restart_s3;
	logic signed [48:0] pp_s3;
	logic signed [63:0] pi_s3;
	logic signed [49:0] pd_s3;
	logic               v_s4;
	corr_pl_t           pl_s4;

	logic               ready_s3;
	logic               ready_s4;
	logic               take_s3;
	logic               take_s4;
	logic signed [48:0] pp;
	logic signed [63:0] pi;
	logic signed [49:0] pd;
	logic signed [63:0] acc;
	logic signed [63:0] acc_adj;
	logic signed [63:0] acc_shr;

	assign ready_s4 = !v_s4 || dn_ready;
	assign ready_s3 = !v_s3 || ready_s4;
	assign up_ready = ready_s3;
	assign take_s3  = up_valid && ready_s3;
	assign take_s4  = v_s3 && ready_s4;
	assign dn_valid = v_s4;
	assign dn       = pl_s4;

	assign pp = $signed(cfg.gain_prop) * $signed(up.err);
	assign pi = $signed(cfg.gain_integ) * $signed(up.esum);
	assign pd = $signed(cfg.gain_deriv) * $signed(up.deriv);

	always_comb begin
		acc = {{15{pp_s3[48]}}, pp_s3} + pi_s3 + {{14{pd_s3[49]}}, pd_s3};
		if (acc[63]) begin
			acc_adj = acc + {{(64 - FracBits){1'b0}}, {FracBits{1'b1}}};
		end else begin
			acc_adj = acc;
		end
		acc_shr = acc_adj >>> FracBits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (take_s3) begin
				v_s3 <= 1'b1;
			end else if (ready_s4) begin
				v_s3 <= 1'b0;
			end
			if (take_s4) begin
				v_s4 <= 1'b1;
			end else if (dn_ready) begin
				v_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3) begin
			restart_s3 <= up.restart;
			pp_s3      <= pp;
			pi_s3      <= pi;
			pd_s3      <= pd;
		end
		if (take_s4) begin
			pl_s4.restart <= restart_s3;
			pl_s4.corr    <= acc_shr[39:0];
		end
	end

endmodule

@@ rtl/core/psr_duty_clamp.sv @@
// ----------------------------------------------------------------------------
// PID speed regulator duty update
// Applies the correction to the stored duty, clamps it and holds the result.
// ----------------------------------------------------------------------------
module psr_duty_clamp (
	input  logic                clk,
	input  logic                arst_n,
	input  psr_pkg::cfg_t       cfg,
	input  logic                up_valid,
	output logic                up_ready,
	input  psr_pkg::corr_pl_t   up,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [15:0]         duty_out,
	output logic                duty_clamped
);
	import psr_pkg::*;

	logic [15:0] duty_q;
	logic        out_valid_q;
	logic [15:0] out_duty_q;
	logic        out_clamped_q;

	logic               take;
	logic signed [40:0] cand;
	logic [15:0]        next_duty;
	logic               next_clamped;

	assign up_ready     = !out_valid_q || rsp_ready;
	assign take         = up_valid && up_ready;
	assign rsp_valid    = out_valid_q;
	assign duty_out     = out_duty_q;
	assign duty_clamped = out_clamped_q;

	always_comb begin
		cand = $signed({25'd0, duty_q}) + $signed({up.corr[39], up.corr});
		if (up.restart) begin
			next_duty    = cfg.duty_default;
			next_clamped = 1'b0;
		end else if (cand < $signed({25'd0, cfg.duty_floor})) begin
			next_duty    = cfg.duty_floor;
			next_clamped = 1'b1;
		end else if (cand > $signed({25'd0, cfg.duty_ceiling})) begin
			next_duty    = cfg.duty_ceiling;
			next_clamped = 1'b1;
		end else begin
			next_duty    = cand[15:0];
			next_clamped = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			duty_q      <= DutyDefaultRst;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				duty_q      <= next_duty;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_duty_q    <= next_duty;
			out_clamped_q <= next_clamped;
		end
	end

endmodule

@@ rtl/core/pid_speed_regulator.sv @@
// ----------------------------------------------------------------------------
// PID speed regulator
// Regulates PWM duty from measured motor speed with a fixed-point PID loop.
// ----------------------------------------------------------------------------
//   Channel   Handshake           Payload
//   request   req_valid/ready     req_type, speed_rpm
//   result    rsp_valid/ready     duty_out, duty_clamped
//   config    APB psel/penable    paddr, pwdata, prdata
//
// One request is taken per cycle while req_ready is high; each result passes
// through the five registers of the input, error, product, correction and
// result stages. Reset loads the register defaults, sets the duty to 32768
// and empties the pipeline. A stalled result holds each stage only while the
// one after it is full, so empty stages keep filling.
// ----------------------------------------------------------------------------
module pid_speed_regulator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       req_type,
	input  logic [15:0]                speed_rpm,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [15:0]                duty_out,
	output logic                       duty_clamped,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [psr_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import psr_pkg::*;

	cfg_t        cfg;
	logic        v_s1;
	logic        restart_s1;
	logic [15:0] speed_s1;

	logic        err_ready;
	logic        err_valid;
	err_pl_t     err_pl;
	logic        mul_ready;
	logic        corr_valid;
	corr_pl_t    corr_pl;
	logic        duty_ready;
	logic        take;

	assign req_ready = !v_s1 || err_ready;
	assign take      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (err_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			restart_s1 <= (req_kind_t'(req_type) == REQ_RESTART);
			speed_s1   <= speed_rpm;
		end
	end

	psr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psr_err_track u_err (
		.clk        (clk),
		.arst_n     (arst_n),
		.setpoint   (cfg.setpoint),
		.up_valid   (v_s1),
		.up_ready   (err_ready),
		.up_restart (restart_s1),
		.up_speed   (speed_s1),
		.dn_valid   (err_valid),
		.dn_ready   (mul_ready),
		.dn         (err_pl)
	);

	psr_gain_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (err_valid),
		.up_ready (mul_ready),
		.up       (err_pl),
		.dn_valid (corr_valid),
		.dn_ready (duty_ready),
		.dn       (corr_pl)
	);

	psr_duty_clamp u_duty (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.up_valid     (corr_valid),
		.up_ready     (duty_ready),
		.up           (corr_pl),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.duty_out     (duty_out),
		.duty_clamped (duty_clamped)
	);

endmodule

@@ bench/pid_speed_regulator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID speed regulator testbench
// Drives speed requests and register writes into the regulator and checks
// every duty result against a table value or a cycle-free PID model held in
// the bench. A short table of directed requests covers the limits and clamp
// cases, then random phases run under changing gains and duty limits, with
// random stalls on both channels and a sustained stall on the result channel.
// ----------------------------------------------------------------------------
module pid_speed_regulator_tb;

	import psr_pkg::*;

	localparam int unsigned RegUnmapped = 7;
	localparam int unsigned QuietLimit  = 1000;

	typedef enum int unsigned {
		GAIN_DAMPING,
		GAIN_PUSHING,
		GAIN_ANY
	} gain_style_t;

	typedef struct packed {
		logic [15:0] duty;
		logic        clamped;
	} duty_res_t;

	typedef struct {
		bit          is_cfg;
		int unsigned idx;
		logic [31:0] value;
		req_kind_t   kind;
		logic [15:0] speed;
		bit          known;
		duty_res_t   typed;
	} step_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              req_valid    = 1'b0;
	logic              req_ready;
	logic              req_type     = REQ_TICK;
	logic [15:0]       speed_rpm    = 16'd0;
	logic              rsp_valid;
	logic              rsp_ready    = 1'b0;
	logic [15:0]       duty_out;
	logic              duty_clamped;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [AddrW-1:0]  paddr        = '0;
	logic [31:0]       pwdata       = 32'd0;
	logic [31:0]       prdata;
	logic              pready;

	logic [15:0]        cfg_setpoint = SetpointRst;
	logic signed [31:0] cfg_kp       = GainPropRst;
	logic signed [31:0] cfg_ki       = GainIntegRst;
	logic signed [31:0] cfg_kd       = GainDerivRst;
	logic [15:0]        cfg_floor    = DutyFloorRst;
	logic [15:0]        cfg_ceiling  = DutyCeilingRst;
	logic [15:0]        cfg_default  = DutyDefaultRst;

	logic [15:0]        pred_duty     = DutyDefaultRst;
	logic signed [16:0] pred_err_prev = '0;
	logic signed [31:0] pred_esum     = '0;

	duty_res_t   duty_expected[$];
	step_t       directed_steps[$];
	int unsigned faults      = 0;
	int unsigned quiet       = 0;
	int unsigned stall_left  = 0;
	bit          stall_armed = 1'b0;
	bit          steady      = 1'b0;

	pid_speed_regulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.speed_rpm    (speed_rpm),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.duty_out     (duty_out),
		.duty_clamped (duty_clamped),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic duty_res_t regulate(req_kind_t kind, logic [15:0] speed);
		longint    err;
		longint    total;
		longint    deriv;
		longint    acc;
		longint    corr;
		longint    cand;
		duty_res_t r;
		if (kind == REQ_RESTART) begin
			pred_duty     = cfg_default;
			pred_err_prev = '0;
			pred_esum     = '0;
			r.duty        = pred_duty;
			r.clamped     = 1'b0;
			return r;
		end
		err   = longint'(speed) - longint'(cfg_setpoint);
		total = longint'(pred_esum) + err;
		if (total > 64'sd2147483647)
			total = 64'sd2147483647;
		if (total < -64'sd2147483648)
			total = -64'sd2147483648;
		pred_esum = total[31:0];
		deriv = err - longint'(pred_err_prev);
		acc   = longint'(cfg_kp) * err + longint'(cfg_ki) * longint'(pred_esum)
			+ longint'(cfg_kd) * deriv;
		corr  = acc / (longint'(1) << FracBits);
		pred_err_prev = err[16:0];
		cand  = longint'(pred_duty) + corr;
		r.clamped = 1'b1;
		if (cand < longint'(cfg_floor)) begin
			pred_duty = cfg_floor;
		end else if (cand > longint'(cfg_ceiling)) begin
			pred_duty = cfg_ceiling;
		end else begin
			pred_duty = cand[15:0];
			r.clamped = 1'b0;
		end
		r.duty = pred_duty;
		return r;
	endfunction

	function automatic void note_register(int unsigned idx, logic [31:0] value);
		case (idx)
			REG_SETPOINT:     cfg_setpoint = value[15:0];
			REG_GAIN_PROP:    cfg_kp       = value;
			REG_GAIN_INTEG:   cfg_ki       = value;
			REG_GAIN_DERIV:   cfg_kd       = value;
			REG_DUTY_FLOOR:   cfg_floor    = value[15:0];
			REG_DUTY_CEILING: cfg_ceiling  = value[15:0];
			REG_DUTY_DEFAULT: cfg_default  = value[15:0];
			default: ;
		endcase
	endfunction

	function automatic void cfg_row(int unsigned idx, logic [31:0] value);
		step_t s;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.value  = value;
		s.kind   = REQ_TICK;
		s.speed  = 16'd0;
		s.known  = 1'b0;
		s.typed  = '0;
		directed_steps.push_back(s);
	endfunction

	function automatic void req_row(req_kind_t kind, logic [15:0] speed, bit known,
			logic [15:0] duty, logic clamped);
		step_t s;
		s.is_cfg        = 1'b0;
		s.idx           = 0;
		s.value         = 32'd0;
		s.kind          = kind;
		s.speed         = speed;
		s.known         = known;
		s.typed.duty    = duty;
		s.typed.clamped = clamped;
		directed_steps.push_back(s);
	endfunction

	function automatic logic [31:0] gain_pick(gain_style_t style);
		logic [31:0] mag;
		mag = $urandom_range(0, 1 << 22);
		case (style)
			GAIN_DAMPING: return -mag;
			GAIN_PUSHING: return mag;
			default:      return $urandom;
		endcase
	endfunction

	task automatic offer(req_kind_t kind, logic [15:0] speed, bit known, duty_res_t typed);
		duty_res_t guess;
		if (!steady && $urandom_range(99) < 13) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		speed_rpm <= speed;
		do @(posedge clk); while (!req_ready);
		guess = regulate(kind, speed);
		duty_expected.push_back(known ? typed : guess);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (duty_expected.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(int unsigned idx, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		note_register(idx, value);
	endtask

	function automatic logic [15:0] near_setpoint();
		int val;
		val = int'(cfg_setpoint) + int'($urandom_range(0, 4000)) - 2000;
		if (val < 0)
			val = 0;
		if (val > 65535)
			val = 65535;
		return val[15:0];
	endfunction

	always @(posedge clk) begin
		duty_res_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (duty_expected.size() == 0) begin
					faults++;
					if (faults <= 40)
						$display("%0t: expected no result, got duty %0d clamped %0d",
							$time, duty_out, duty_clamped);
				end else begin
					want = duty_expected.pop_front();
					if (duty_out !== want.duty) begin
						faults++;
						if (faults <= 40)
							$display("%0t: duty_out expected %0d, got %0d",
								$time, want.duty, duty_out);
					end
					if (duty_clamped !== want.clamped) begin
						faults++;
						if (faults <= 40)
							$display("%0t: duty_clamped expected %0d, got %0d",
								$time, want.clamped, duty_clamped);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (stall_armed) begin
				stall_armed = 1'b0;
				stall_left  = 79;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= steady || ($urandom_range(99) >= 13);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= QuietLimit) begin
			$display("%0t: no request or result moved for %0d cycles", $time, quiet);
			$display("pid_speed_regulator_tb: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		step_t       s;
		gain_style_t style;
		logic [15:0] lo;
		logic [15:0] hi;
		int unsigned roll;

		req_row(REQ_RESTART, 16'd0, 1'b1, 16'd32768, 1'b0);
		req_row(REQ_TICK, 16'd1000, 1'b1, 16'd32768, 1'b0);
		req_row(REQ_TICK, 16'd0, 1'b0, 16'd0, 1'b0);
		req_row(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 1'b0);
		req_row(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 1'b0);
		req_row(REQ_RESTART, 16'hFFFF, 1'b1, 16'd32768, 1'b0);
		cfg_row(REG_SETPOINT, 32'd0);
		cfg_row(REG_GAIN_PROP, 32'h7FFF_FFFF);
		cfg_row(REG_GAIN_INTEG, 32'd0);
		cfg_row(REG_GAIN_DERIV, 32'd0);
		req_row(REQ_TICK, 16'hFFFF, 1'b1, 16'd65535, 1'b1);
		cfg_row(REG_GAIN_PROP, 32'h8000_0000);
		req_row(REQ_TICK, 16'hFFFF, 1'b1, 16'd0, 1'b1);
		// Floor above ceiling: the floor test is made first.
		cfg_row(REG_GAIN_PROP, 32'd0);
		cfg_row(REG_DUTY_FLOOR, 32'd100);
		cfg_row(REG_DUTY_CEILING, 32'd50);
		req_row(REQ_TICK, 16'd0, 1'b1, 16'd100, 1'b1);
		req_row(REQ_TICK, 16'd0, 1'b1, 16'd50, 1'b1);
		cfg_row(REG_DUTY_DEFAULT, 32'd12345);
		req_row(REQ_TICK, 16'd0, 1'b1, 16'd100, 1'b1);
		cfg_row(REG_DUTY_FLOOR, 32'd0);
		cfg_row(REG_DUTY_CEILING, 32'd65535);
		req_row(REQ_TICK, 16'd0, 1'b1, 16'd100, 1'b0);
		req_row(REQ_RESTART, 16'hFFFF, 1'b1, 16'd12345, 1'b0);
		// A duty equal to a limit is not reported as clamped.
		cfg_row(REG_DUTY_CEILING, 32'd12345);
		req_row(REQ_TICK, 16'd7, 1'b1, 16'd12345, 1'b0);
		cfg_row(REG_DUTY_FLOOR, 32'd12345);
		cfg_row(REG_DUTY_CEILING, 32'd65535);
		req_row(REQ_TICK, 16'd7, 1'b1, 16'd12345, 1'b0);
		cfg_row(REG_DUTY_FLOOR, 32'd0);
		cfg_row(REG_SETPOINT, 32'd65535);
		cfg_row(REG_GAIN_DERIV, 32'h8000_0000);
		req_row(REQ_TICK, 16'd0, 1'b1, 16'd65535, 1'b1);
		req_row(REQ_TICK, 16'hFFFF, 1'b1, 16'd0, 1'b1);
		cfg_row(REG_GAIN_DERIV, 32'd0);
		cfg_row(REG_GAIN_INTEG, 32'h7FFF_FFFF);
		req_row(REQ_TICK, 16'hFFFF, 1'b1, 16'd0, 1'b1);
		cfg_row(REG_GAIN_INTEG, 32'h8000_0000);
		req_row(REQ_TICK, 16'hFFFF, 1'b1, 16'd65535, 1'b1);
		cfg_row(REG_SETPOINT, {16'd0, SetpointRst});
		cfg_row(REG_GAIN_PROP, GainPropRst);
		cfg_row(REG_GAIN_INTEG, GainIntegRst);
		cfg_row(REG_GAIN_DERIV, GainDerivRst);
		cfg_row(REG_DUTY_DEFAULT, {16'd0, DutyDefaultRst});
		cfg_row(RegUnmapped, 32'hFFFF_FFFF);
		req_row(REQ_RESTART, 16'd0, 1'b1, 16'd32768, 1'b0);
		req_row(REQ_TICK, 16'h5555, 1'b0, 16'd0, 1'b0);
		req_row(REQ_TICK, 16'hAAAA, 1'b0, 16'd0, 1'b0);
		req_row(REQ_TICK, 16'd999, 1'b0, 16'd0, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			s = directed_steps[i];
			if (s.is_cfg) begin
				settle();
				reg_write(s.idx, s.value);
			end else begin
				offer(s.kind, s.speed, s.known, s.typed);
			end
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			lo = 16'd0;
			hi = 16'd65535;
			case (p)
				0: style = GAIN_DAMPING;
				1: begin
					style = GAIN_ANY;
					lo = 16'($urandom_range(0, 30000));
					hi = 16'($urandom_range(lo, 65535));
				end
				2: begin
					style = GAIN_DAMPING;
					lo = 16'($urandom_range(0, 30000));
					hi = 16'($urandom_range(lo, 65535));
				end
				3: begin
					style = GAIN_PUSHING;
					lo = 16'($urandom_range(30001, 65535));
					hi = 16'($urandom_range(0, 30000));
				end
				4: style = GAIN_DAMPING;
				default: begin
					style = GAIN_DAMPING;
					lo = 16'($urandom_range(0, 65535));
					hi = lo;
				end
			endcase
			reg_write(REG_SETPOINT, $urandom_range(0, 65535));
			reg_write(REG_GAIN_PROP, gain_pick(style));
			reg_write(REG_GAIN_INTEG, gain_pick(style));
			reg_write(REG_GAIN_DERIV, gain_pick(style));
			reg_write(REG_DUTY_FLOOR, {16'd0, lo});
			reg_write(REG_DUTY_CEILING, {16'd0, hi});
			reg_write(REG_DUTY_DEFAULT, $urandom_range(0, 65535));
			if (p == 4)
				reg_write(RegUnmapped, $urandom);
			steady = (p == 3);
			offer(REQ_RESTART, 16'($urandom), 1'b0, '0);
			for (int n = 0; n < 105; n++) begin
				if (p == 2 && n == 20)
					stall_armed = 1'b1;
				if (p == 4 && n == 50)
					settle();
				roll = $urandom_range(99);
				if (roll < 5)
					offer(REQ_RESTART, 16'($urandom), 1'b0, '0);
				else if (roll < 20)
					offer(REQ_TICK, 16'($urandom), 1'b0, '0);
				else
					offer(REQ_TICK, near_setpoint(), 1'b0, '0);
			end
		end
		steady = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (faults == 0) begin
			$display("pid_speed_regulator_tb: PASS");
		end else begin
			$display("pid_speed_regulator_tb: FAIL");
		end
		$finish;
	end

endmodule
